@@ src/plvta_pkg.sv @@
// Package for the price level volume threshold alert block.
// Holds the transfer payload types, configuration register indexes, compare
// mode codes and arithmetic constants. It has no dependencies.
package plvta_pkg;

    // Sizes of the fixed fields and of the configuration port.
    localparam int unsigned DataW    = 32;
    localparam int unsigned IndexW   = 10;
    localparam int unsigned CountW   = 11;
    localparam int unsigned SlotW    = 3;
    localparam int unsigned ModeW    = 4;
    localparam int unsigned CfgIdxW  = 3;

    // Defaults of the block parameters.
    localparam int unsigned MaxLevelsDefault = 1024;
    localparam int unsigned MaxRunsDefault   = 5;

    // Arithmetic constants: percent scale, zero-divisor result, count cap.
    localparam int unsigned Pct      = 100;
    localparam int unsigned ZeroPct  = 1000;
    localparam int unsigned CountMax = 2047;

    // The dividend is the 32-bit volume times 100, so it needs 39 bits.
    localparam int unsigned DividendW = 39;
    localparam int unsigned DivSteps  = DividendW;
    localparam int unsigned StepW     = $clog2(DivSteps);

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_COMPARE_MODE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_VOLUME_LIMIT  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PERCENT_LIMIT = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ASK_LIMIT     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ZERO_COMPARE  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_ZERO_ACTION   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_MIN_RUN_SIZE  = 3'd6;

    // Compare mode codes.
    localparam logic [ModeW-1:0] MODE_BID        = 4'd0;
    localparam logic [ModeW-1:0] MODE_ASK        = 4'd1;
    localparam logic [ModeW-1:0] MODE_TOTAL      = 4'd2;
    localparam logic [ModeW-1:0] MODE_TRADES     = 4'd3;
    localparam logic [ModeW-1:0] MODE_DIFF       = 4'd4;
    localparam logic [ModeW-1:0] MODE_DIAG_DIFF  = 4'd5;
    localparam logic [ModeW-1:0] MODE_RATIO      = 4'd6;
    localparam logic [ModeW-1:0] MODE_DIAG_RATIO = 4'd7;
    localparam logic [ModeW-1:0] MODE_BOTH       = 4'd8;

    // Configuration reset values.
    localparam logic [ModeW-1:0]  RstCompareMode  = MODE_TOTAL;
    localparam logic [DataW-1:0]  RstVolumeLimit  = 32'd100;
    localparam logic [DataW-1:0]  RstPercentLimit = 32'd150;
    localparam logic [DataW-1:0]  RstAskLimit     = 32'd100;
    localparam logic [CountW-1:0] RstMinRunSize   = 11'd0;

    // One price level of a bar.
    typedef struct packed {
        logic              bar_start;
        logic [IndexW-1:0] level_index;
        logic [DataW-1:0]  price_ticks;
        logic [DataW-1:0]  bid_volume;
        logic [DataW-1:0]  ask_volume;
        logic [DataW-1:0]  total_volume;
        logic [DataW-1:0]  trade_count;
        logic              has_next;
        logic [DataW-1:0]  next_ask_volume;
        logic [DataW-1:0]  next_price_ticks;
    } t_in_item;

    // Alert result for one price level.
    typedef struct packed {
        logic              alert;
        logic [DataW-1:0]  marked_price_ticks;
        logic [DataW-1:0]  line_price_ticks;
        logic [CountW-1:0] alert_total;
        logic [SlotW-1:0]  run_slot;
        logic              run_bottom_mark;
        logic              run_top_mark;
    } t_out_item;

endpackage

@@ src/price_level_volume_threshold_alert_top.sv @@
// Top level of the price level volume threshold alert block.
// Depends on plvta_pkg for payload types, register indexes and mode codes.
// Steps: the idle state latches the level, the evaluate state picks operands, and
// the finish state writes the result; ratio modes that divide pass through the
// restoring divider steps and a rounding step before finish. One level is in work
// at a time, so a new level is taken only after the last one has been written to
// the output register, which waits while results are stalled. Synchronous active-low
// reset restores register defaults, clears bar state and output valid, and stalls input.
module price_level_volume_threshold_alert_top #(
    parameter int unsigned MAX_LEVELS = plvta_pkg::MaxLevelsDefault,
    parameter int unsigned MAX_RUNS   = plvta_pkg::MaxRunsDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  plvta_pkg::t_in_item                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output plvta_pkg::t_out_item                  o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [plvta_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [plvta_pkg::DataW-1:0]           i_cfg_data
);

    localparam int unsigned DW   = plvta_pkg::DataW;
    localparam int unsigned CW   = plvta_pkg::CountW;
    localparam int unsigned NW   = plvta_pkg::DividendW;
    localparam int unsigned SW   = plvta_pkg::StepW;
    localparam int unsigned RunW = $clog2(MAX_RUNS + 1) + 1;
    localparam int unsigned CapI = (MAX_LEVELS < plvta_pkg::CountMax) ?
                                   MAX_LEVELS : plvta_pkg::CountMax;
    localparam logic [CW-1:0]          AlertCap  = CW'(CapI);
    localparam logic [CW-1:0]          LenMax    = CW'(plvta_pkg::CountMax);
    localparam logic signed [RunW-1:0] RunMax    = RunW'(MAX_RUNS);
    localparam logic signed [RunW-1:0] RunNone   = -RunW'(1);
    localparam logic [DW-1:0]          PosZero   = DW'(plvta_pkg::ZeroPct);
    localparam logic [DW-1:0]          NegZero   = -DW'(plvta_pkg::ZeroPct);
    localparam logic [NW:0]            SatPos    = (NW+1)'(32'h7fff_ffff);
    localparam logic [NW:0]            SatNeg    = (NW+1)'(32'h8000_0000);
    localparam logic [SW-1:0]          LastStep  = SW'(plvta_pkg::DivSteps - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_ROUND,
        ST_FINISH
    } t_state;

    // Control and configuration registers.
    t_state                       r_state;
    logic [plvta_pkg::ModeW-1:0]  r_mode;
    logic [DW-1:0]                r_vol_limit;
    logic [DW-1:0]                r_pct_limit;
    logic [DW-1:0]                r_ask_limit;
    logic                         r_zero_ok;
    logic                         r_zero_act;
    logic [CW-1:0]                r_min_run;

    // Per-bar run tracking state.
    logic                         r_run_open;
    logic [plvta_pkg::IndexW-1:0] r_run_base;
    logic [CW-1:0]                r_run_len;
    logic                         r_run_qual;
    logic signed [RunW-1:0]       r_run_num;
    logic [CW-1:0]                r_alert_cnt;

    // Datapath registers of the level in work.
    plvta_pkg::t_in_item          r_item;
    logic [DW-1:0]                r_ratio;
    logic [DW-1:0]                r_marked;
    logic [DW-1:0]                r_line;
    logic                         r_neg;
    logic [NW-1:0]                r_quo;
    logic [DW-1:0]                r_rem;
    logic [DW-1:0]                r_den;
    logic [SW-1:0]                r_step;

    // Output register.
    logic                         r_out_valid;
    plvta_pkg::t_out_item         r_out;

    // Evaluation of the latched level: picks the ratio operands or a direct value.
    logic          e_need_div;
    logic [DW-1:0] e_num;
    logic [DW-1:0] e_den;
    logic          e_neg;
    logic [DW-1:0] e_r;
    logic [DW-1:0] e_marked;
    logic [DW-1:0] e_line;
    logic [NW-1:0] e_dividend;

    always_comb begin
        e_need_div = 1'b0;
        e_num      = '0;
        e_den      = '0;
        e_neg      = 1'b0;
        e_r        = '0;
        e_marked   = r_item.price_ticks;
        e_line     = r_item.price_ticks;
        case (r_mode)
            plvta_pkg::MODE_DIFF: begin
                e_r = r_item.ask_volume - r_item.bid_volume;
            end
            plvta_pkg::MODE_DIAG_DIFF: begin
                if (r_item.has_next) begin
                    e_r = r_item.next_ask_volume - r_item.bid_volume;
                    if (r_item.next_ask_volume > r_item.bid_volume) begin
                        e_line = r_item.next_price_ticks;
                    end
                end
            end
            plvta_pkg::MODE_RATIO: begin
                if ((r_item.ask_volume != '0 && r_item.bid_volume != '0) || r_zero_ok) begin
                    if (r_item.ask_volume >= r_item.bid_volume) begin
                        if (r_item.bid_volume == '0 && r_zero_act) begin
                            e_r = PosZero;
                        end else begin
                            e_need_div = 1'b1;
                            e_num      = r_item.ask_volume;
                            e_den      = r_item.bid_volume;
                        end
                    end else begin
                        if (r_item.ask_volume == '0 && r_zero_act) begin
                            e_r = NegZero;
                        end else begin
                            e_need_div = 1'b1;
                            e_num      = r_item.bid_volume;
                            e_den      = r_item.ask_volume;
                            e_neg      = 1'b1;
                        end
                    end
                end
            end
            plvta_pkg::MODE_DIAG_RATIO: begin
                if (r_item.has_next) begin
                    if (r_item.next_ask_volume >= r_item.bid_volume &&
                        (r_item.bid_volume != '0 || r_zero_ok)) begin
                        e_marked = r_item.next_price_ticks;
                        e_line   = r_item.next_price_ticks;
                        if (r_item.bid_volume == '0 && r_zero_act) begin
                            e_r = PosZero;
                        end else begin
                            e_need_div = 1'b1;
                            e_num      = r_item.next_ask_volume;
                            e_den      = r_item.bid_volume;
                        end
                    end else if (r_item.bid_volume > r_item.next_ask_volume &&
                                 (r_item.next_ask_volume != '0 || r_zero_ok)) begin
                        if (r_item.next_ask_volume == '0 && r_zero_act) begin
                            e_r = NegZero;
                        end else begin
                            e_need_div = 1'b1;
                            e_num      = r_item.bid_volume;
                            e_den      = r_item.next_ask_volume;
                            e_neg      = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        e_dividend = NW'(e_num) * NW'(plvta_pkg::Pct);
    end

    // One restoring divider step: shift in the next dividend bit and try to subtract.
    logic [DW:0]   d_trial;
    logic          d_fit;
    logic [DW:0]   d_diff;

    always_comb begin
        d_trial = {r_rem, r_quo[NW-1]};
        d_diff  = d_trial - {1'b0, r_den};
        d_fit   = (d_trial >= {1'b0, r_den});
    end

    // Rounding to nearest with halves up, then sign and saturation.
    logic          q_up;
    logic [NW:0]   q_round;
    logic [DW-1:0] q_ratio;

    always_comb begin
        q_up    = ({r_rem, 1'b0} >= {1'b0, r_den});
        q_round = {1'b0, r_quo} + (NW+1)'(q_up);
        if (!r_neg) begin
            q_ratio = (q_round > SatPos) ? 32'h7fff_ffff : q_round[DW-1:0];
        end else begin
            q_ratio = (q_round > SatNeg) ? 32'h8000_0000 : -q_round[DW-1:0];
        end
    end

    // Threshold test, alert count and run tracking for the finished level.
    logic                         f_hit;
    logic                         f_plain_bid;
    logic                         f_plain_ask;
    logic [DW-1:0]                f_limit;
    logic                         f_open;
    logic [plvta_pkg::IndexW-1:0] f_base;
    logic [CW-1:0]                f_len;
    logic                         f_qual;
    logic signed [RunW-1:0]       f_num;
    logic [CW-1:0]                f_cnt;
    logic                         f_bmark;
    logic                         f_tmark;
    logic [CW:0]                  f_next_idx;
    plvta_pkg::t_out_item         f_out;

    function automatic logic plain_test(input logic [31:0] limit, input logic [31:0] v);
        plain_test = (limit != '0 && v >= limit) || (limit == '0 && v == '0);
    endfunction

    function automatic logic signed_test(input logic [31:0] r, input logic [31:0] lim);
        logic signed [31:0] sr;
        logic signed [31:0] sl;
        sr = $signed(r);
        sl = $signed(lim);
        signed_test = (sr > 0 && sl > 0 && sr >= sl) || (sr < 0 && sl < 0 && sr <= sl);
    endfunction

    always_comb begin
        f_plain_bid = plain_test(r_vol_limit, r_item.bid_volume);
        f_plain_ask = plain_test(r_ask_limit, r_item.ask_volume);
        f_limit     = (r_mode == plvta_pkg::MODE_RATIO || r_mode == plvta_pkg::MODE_DIAG_RATIO) ?
                      r_pct_limit : r_vol_limit;
        case (r_mode)
            plvta_pkg::MODE_BID:        f_hit = f_plain_bid;
            plvta_pkg::MODE_ASK:        f_hit = plain_test(r_vol_limit, r_item.ask_volume);
            plvta_pkg::MODE_TOTAL:      f_hit = plain_test(r_vol_limit, r_item.total_volume);
            plvta_pkg::MODE_TRADES:     f_hit = plain_test(r_vol_limit, r_item.trade_count);
            plvta_pkg::MODE_DIFF:       f_hit = signed_test(r_ratio, f_limit);
            plvta_pkg::MODE_DIAG_DIFF:  f_hit = signed_test(r_ratio, f_limit);
            plvta_pkg::MODE_RATIO:      f_hit = signed_test(r_ratio, f_limit);
            plvta_pkg::MODE_DIAG_RATIO: f_hit = signed_test(r_ratio, f_limit);
            plvta_pkg::MODE_BOTH:       f_hit = f_plain_bid && f_plain_ask;
            default:                    f_hit = 1'b0;
        endcase

        // A new bar starts from cleared state.
        if (r_item.bar_start) begin
            f_open = 1'b0;
            f_base = '0;
            f_len  = '0;
            f_qual = 1'b0;
            f_num  = RunNone;
            f_cnt  = '0;
        end else begin
            f_open = r_run_open;
            f_base = r_run_base;
            f_len  = r_run_len;
            f_qual = r_run_qual;
            f_num  = r_run_num;
            f_cnt  = r_alert_cnt;
        end
        f_bmark    = 1'b0;
        f_tmark    = 1'b0;
        f_next_idx = (CW+1)'(f_base) + (CW+1)'(f_len);

        if (f_hit) begin
            if (f_cnt < AlertCap) begin
                f_cnt = f_cnt + CW'(1);
            end
            if (r_min_run != '0 && f_num < RunMax) begin
                // A gap closes the open run; an unqualified run gives its slot back.
                if (f_open && (CW+1)'(r_item.level_index) != f_next_idx) begin
                    f_open = 1'b0;
                    f_len  = '0;
                    if (!f_qual) begin
                        f_num = f_num - RunW'(1);
                    end
                    f_qual = 1'b0;
                end
                if (!f_open) begin
                    f_num   = f_num + RunW'(1);
                    f_open  = 1'b1;
                    f_len   = CW'(1);
                    f_base  = r_item.level_index;
                    f_bmark = (f_num < RunMax);
                end else if (f_len < LenMax) begin
                    f_len = f_len + CW'(1);
                end
                if (f_len >= r_min_run) begin
                    f_qual  = 1'b1;
                    f_tmark = (f_num < RunMax);
                end
            end
        end

        f_out.alert              = f_hit;
        f_out.marked_price_ticks = r_marked;
        f_out.line_price_ticks   = r_line;
        f_out.alert_total        = f_cnt;
        f_out.run_slot           = (f_num >= 0 && f_num < RunMax) ?
                                   plvta_pkg::SlotW'($unsigned(f_num)) : '0;
        f_out.run_bottom_mark    = f_bmark;
        f_out.run_top_mark       = f_tmark;
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= plvta_pkg::RstCompareMode;
            r_vol_limit <= plvta_pkg::RstVolumeLimit;
            r_pct_limit <= plvta_pkg::RstPercentLimit;
            r_ask_limit <= plvta_pkg::RstAskLimit;
            r_zero_ok   <= 1'b0;
            r_zero_act  <= 1'b0;
            r_min_run   <= plvta_pkg::RstMinRunSize;
            r_run_open  <= 1'b0;
            r_run_base  <= '0;
            r_run_len   <= '0;
            r_run_qual  <= 1'b0;
            r_run_num   <= RunNone;
            r_alert_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    plvta_pkg::CFG_COMPARE_MODE:  r_mode      <= i_cfg_data[plvta_pkg::ModeW-1:0];
                    plvta_pkg::CFG_VOLUME_LIMIT:  r_vol_limit <= i_cfg_data;
                    plvta_pkg::CFG_PERCENT_LIMIT: r_pct_limit <= i_cfg_data;
                    plvta_pkg::CFG_ASK_LIMIT:     r_ask_limit <= i_cfg_data;
                    plvta_pkg::CFG_ZERO_COMPARE:  r_zero_ok   <= i_cfg_data[0];
                    plvta_pkg::CFG_ZERO_ACTION:   r_zero_act  <= i_cfg_data[0];
                    plvta_pkg::CFG_MIN_RUN_SIZE:  r_min_run   <= i_cfg_data[CW-1:0];
                    default: begin
                    end
                endcase
            end

            // The result leaves when the receiver takes it; the finish step
            // refills the register itself in that cycle.
            if (r_out_valid && !i_out_stall && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_ratio  <= e_r;
                    r_marked <= e_marked;
                    r_line   <= e_line;
                    r_neg    <= e_neg;
                    r_quo    <= e_dividend;
                    r_rem    <= '0;
                    r_den    <= (e_den == '0) ? DW'(1) : e_den;
                    r_step   <= '0;
                    r_state  <= e_need_div ? ST_DIV : ST_FINISH;
                end
                ST_DIV: begin
                    r_quo  <= {r_quo[NW-2:0], d_fit};
                    r_rem  <= d_fit ? d_diff[DW-1:0] : d_trial[DW-1:0];
                    r_step <= r_step + SW'(1);
                    if (r_step == LastStep) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_ratio <= q_ratio;
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= f_out;
                        r_out_valid <= 1'b1;
                        r_run_open  <= f_open;
                        r_run_base  <= f_base;
                        r_run_len   <= f_len;
                        r_run_qual  <= f_qual;
                        r_run_num   <= f_num;
                        r_alert_cnt <= f_cnt;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
